FILE: sv/lfsa_pkg.sv
// Shared types, constants and helper functions of the lowest free slot allocator.
package lfsa_pkg;

  localparam int IDX_W = 10;
  localparam int CNT_W = 11;
  localparam int WORD_W = 32;
  localparam int BITPOS_W = 5;
  localparam int WNUM_W = 6;
  localparam int INDEX_SPAN = 1024;
  localparam int SLOT_CAPACITY_DEF = 1024;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 16;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BITPOS_W-1:0] bitpos_t;
  typedef logic [WNUM_W-1:0] wnum_t;
  typedef logic [1:0] status_t;
  typedef logic [1:0] op_t;

  localparam cnt_t ACTIVE_RESET = 11'd1024;
  localparam word_t WORD_ONES = 32'hffffffff;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE = 1'b1;

  localparam status_t ST_OK = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_RANGE = 2'd2;
  localparam status_t ST_ALREADY_FREE = 2'd3;

  localparam op_t OP_ALLOC = 2'd0;
  localparam op_t OP_FREE = 2'd1;
  localparam op_t OP_RANGE = 2'd2;

  typedef struct packed {
    op_t op;
    idx_t idx;
  } cmd_t;

  typedef struct packed {
    logic found;
    bitpos_t pos;
  } hit_t;

  function automatic cnt_t eff_limit(cnt_t active, cnt_t cap);
    return (active > cap) ? cap : active;
  endfunction

  function automatic hit_t lowest_set(word_t v);
    hit_t h;
    h.found = |v;
    h.pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        h.pos = bitpos_t'(i);
      end
    end
    return h;
  endfunction

endpackage

FILE: sv/lowest_free_slot_allocator.sv
// Top level of the lowest free slot allocator: limit register, input stage, queue and engine.
// The block hands out the lowest free slot of a pool below the active limit and takes slots
// back on free requests, one result beat per request beat. A request beat is a kind in
// s_axis_tuser (0 allocate, 1 free) and a slot index in s_axis_tdata; the result beat
// carries a status code and the granted slot. The input stage and a two-deep command queue
// keep taking requests while the engine works. The engine keeps occupancy in 32-bit words
// of a single-port memory. A free reads its word on leaving the queue, then checks and
// clears the bit and sets its result; an allocate reads the word of the hint, scans word
// by word for the grant and then for the next free slot above it, and sets its result.
// A request that fails on the count or the index check is answered from idle. Every
// memory word has a valid flag that reset clears, so there is no clearing pass after reset.
module lowest_free_slot_allocator #(
  parameter int SLOT_CAPACITY = lfsa_pkg::SLOT_CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [lfsa_pkg::CNT_W-1:0]          cfg_wr_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lfsa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // slot_index[9:0]
  input  logic [0:0]                          s_axis_tuser,   // req_type[0]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lfsa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata    // status[1:0], granted_slot[11:2]
);

  lfsa_pkg::cnt_t active_slots;
  logic f_valid;
  logic f_ready;
  lfsa_pkg::cmd_t f_cmd;
  logic q_valid;
  logic q_ready;
  lfsa_pkg::cmd_t q_cmd;
  lfsa_pkg::status_t res_status;
  lfsa_pkg::idx_t res_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= lfsa_pkg::ACTIVE_RESET;
    end else if (cfg_wr_en) begin
      active_slots <= cfg_wr_data;
    end
  end

  lfsa_front #(
    .SLOT_CAPACITY(SLOT_CAPACITY)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .active_slots (active_slots),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_req_type  (s_axis_tuser[0]),
    .in_slot_index(s_axis_tdata[lfsa_pkg::IDX_W-1:0]),
    .cmd_valid    (f_valid),
    .cmd_ready    (f_ready),
    .cmd          (f_cmd)
  );

  lfsa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_cmd   (f_cmd),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_cmd  (q_cmd)
  );

  lfsa_back #(
    .SLOT_CAPACITY(SLOT_CAPACITY)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .active_slots(active_slots),
    .cmd_valid   (q_valid),
    .cmd_ready   (q_ready),
    .cmd         (q_cmd),
    .res_valid   (m_axis_tvalid),
    .res_ready   (m_axis_tready),
    .res_status  (res_status),
    .res_slot    (res_slot)
  );

  assign m_axis_tdata = {{(lfsa_pkg::OUT_TDATA_W - lfsa_pkg::IDX_W - 2){1'b0}},
                         res_slot, res_status};

endmodule

FILE: sv/lfsa_front.sv
// Input stage: takes request beats, checks free indexes against the limit, holds one command.
module lfsa_front #(
  parameter int SLOT_CAPACITY = lfsa_pkg::SLOT_CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lfsa_pkg::cnt_t       active_slots,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  lfsa_pkg::idx_t       in_slot_index,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output lfsa_pkg::cmd_t       cmd
);

  localparam int LIM_CAP_I = (SLOT_CAPACITY < lfsa_pkg::INDEX_SPAN) ?
                             SLOT_CAPACITY : lfsa_pkg::INDEX_SPAN;
  localparam lfsa_pkg::cnt_t LIM_CAP = lfsa_pkg::cnt_t'(LIM_CAP_I);

  logic full;
  lfsa_pkg::cnt_t lim;
  lfsa_pkg::cmd_t cmd_class;
  logic accept;

  assign lim = lfsa_pkg::eff_limit(active_slots, LIM_CAP);
  assign in_ready = !full || cmd_ready;
  assign accept = in_valid && in_ready;
  assign cmd_valid = full;

  always_comb begin
    cmd_class.idx = in_slot_index;
    if (in_req_type == lfsa_pkg::REQ_FREE) begin
      if (lfsa_pkg::cnt_t'(in_slot_index) >= lim) begin
        cmd_class.op = lfsa_pkg::OP_RANGE;
      end else begin
        cmd_class.op = lfsa_pkg::OP_FREE;
      end
    end else begin
      cmd_class.op = lfsa_pkg::OP_ALLOC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (cmd_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_class;
    end
  end

endmodule

FILE: sv/lfsa_queue.sv
// Small command queue between the input stage and the slot engine.
module lfsa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lfsa_pkg::cmd_t in_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output lfsa_pkg::cmd_t out_cmd
);

  lfsa_pkg::cmd_t entries [lfsa_pkg::QUEUE_DEPTH];
  logic [lfsa_pkg::QPTR_W-1:0] wp;
  logic [lfsa_pkg::QPTR_W-1:0] rp;
  logic [lfsa_pkg::QCNT_W-1:0] cnt;
  logic push;
  logic pop;

  assign in_ready = cnt != lfsa_pkg::QCNT_W'(lfsa_pkg::QUEUE_DEPTH);
  assign out_valid = cnt != '0;
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;
  assign out_cmd = entries[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= in_cmd;
    end
  end

endmodule

FILE: sv/lfsa_back.sv
// Slot engine: occupancy memory, word-wise free-slot scan, hint and count, result register.
module lfsa_back #(
  parameter int SLOT_CAPACITY = lfsa_pkg::SLOT_CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lfsa_pkg::cnt_t       active_slots,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  lfsa_pkg::cmd_t       cmd,
  output logic                 res_valid,
  input  logic                 res_ready,
  output lfsa_pkg::status_t    res_status,
  output lfsa_pkg::idx_t       res_slot
);

  localparam int LIM_CAP_I = (SLOT_CAPACITY < lfsa_pkg::INDEX_SPAN) ?
                             SLOT_CAPACITY : lfsa_pkg::INDEX_SPAN;
  localparam lfsa_pkg::cnt_t LIM_CAP = lfsa_pkg::cnt_t'(LIM_CAP_I);
  localparam int NWORDS = (LIM_CAP_I + lfsa_pkg::WORD_W - 1) / lfsa_pkg::WORD_W;
  localparam int AW = (NWORDS > 1) ? $clog2(NWORDS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FREE = 2'd1;
  localparam logic [1:0] S_SCAN1 = 2'd2;
  localparam logic [1:0] S_SCAN2 = 2'd3;

  lfsa_pkg::word_t mem [NWORDS];
  logic [NWORDS-1:0] wvalid;
  lfsa_pkg::word_t rd_q;
  logic rdv_q;

  logic [1:0] state;
  logic [1:0] state_next;
  lfsa_pkg::wnum_t w;
  lfsa_pkg::wnum_t w_next;
  lfsa_pkg::wnum_t start;
  lfsa_pkg::wnum_t start_next;
  logic use_buf;
  logic use_buf_next;
  lfsa_pkg::word_t word_buf;
  lfsa_pkg::word_t word_buf_next;
  lfsa_pkg::idx_t cur_idx;
  lfsa_pkg::idx_t cur_idx_next;
  lfsa_pkg::idx_t grant;
  lfsa_pkg::idx_t grant_next;
  lfsa_pkg::idx_t hint;
  lfsa_pkg::idx_t hint_next;
  lfsa_pkg::cnt_t used_count;
  lfsa_pkg::cnt_t used_count_next;

  logic res_set;
  lfsa_pkg::status_t res_status_d;
  lfsa_pkg::idx_t res_slot_d;

  logic rd_en;
  lfsa_pkg::wnum_t rd_addr;
  logic wr_en;
  lfsa_pkg::wnum_t wr_addr;
  lfsa_pkg::word_t wr_data;

  lfsa_pkg::cnt_t lim;
  lfsa_pkg::cnt_t lim_round;
  lfsa_pkg::wnum_t lim_words;
  lfsa_pkg::wnum_t lim_top;
  lfsa_pkg::wnum_t w_inc;
  lfsa_pkg::word_t rd_word;
  lfsa_pkg::word_t scan_word;
  lfsa_pkg::word_t start_mask;
  lfsa_pkg::word_t lim_mask;
  lfsa_pkg::word_t cand;
  lfsa_pkg::hit_t hit;
  logic next_ok;
  lfsa_pkg::bitpos_t free_pos;

  assign lim = lfsa_pkg::eff_limit(active_slots, LIM_CAP);
  assign lim_round = lim + lfsa_pkg::cnt_t'(lfsa_pkg::WORD_W - 1);
  assign lim_words = lim_round[lfsa_pkg::CNT_W-1:lfsa_pkg::BITPOS_W];
  assign lim_top = lim[lfsa_pkg::CNT_W-1:lfsa_pkg::BITPOS_W];
  assign w_inc = w + 1'b1;
  assign next_ok = w_inc < lim_words;
  assign rd_word = rdv_q ? rd_q : '0;
  assign scan_word = use_buf ? word_buf : rd_word;
  assign free_pos = cur_idx[lfsa_pkg::BITPOS_W-1:0];

  always_comb begin
    if (start[lfsa_pkg::WNUM_W-1]) begin
      start_mask = '0;
    end else begin
      start_mask = lfsa_pkg::WORD_ONES << start[lfsa_pkg::BITPOS_W-1:0];
    end
    if (w < lim_top) begin
      lim_mask = lfsa_pkg::WORD_ONES;
    end else if (w == lim_top) begin
      lim_mask = ~(lfsa_pkg::WORD_ONES << lim[lfsa_pkg::BITPOS_W-1:0]);
    end else begin
      lim_mask = '0;
    end
  end

  assign cand = ~scan_word & start_mask & lim_mask;
  assign hit = lfsa_pkg::lowest_set(cand);
  assign cmd_ready = (state == S_IDLE) && (!res_valid || res_ready);

  always_comb begin
    state_next = state;
    w_next = w;
    start_next = start;
    use_buf_next = use_buf;
    word_buf_next = word_buf;
    cur_idx_next = cur_idx;
    grant_next = grant;
    hint_next = hint;
    used_count_next = used_count;
    res_set = 1'b0;
    res_status_d = lfsa_pkg::ST_OK;
    res_slot_d = '0;
    rd_en = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = w;
    wr_data = '0;
    case (state)
      S_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          case (cmd.op)
            lfsa_pkg::OP_ALLOC: begin
              if (used_count >= lim) begin
                res_set = 1'b1;
                res_status_d = lfsa_pkg::ST_FULL;
              end else begin
                rd_en = 1'b1;
                rd_addr = lfsa_pkg::wnum_t'(hint[lfsa_pkg::IDX_W-1:lfsa_pkg::BITPOS_W]);
                w_next = rd_addr;
                start_next = lfsa_pkg::wnum_t'(hint[lfsa_pkg::BITPOS_W-1:0]);
                use_buf_next = 1'b0;
                state_next = S_SCAN1;
              end
            end
            lfsa_pkg::OP_FREE: begin
              rd_en = 1'b1;
              rd_addr = lfsa_pkg::wnum_t'(cmd.idx[lfsa_pkg::IDX_W-1:lfsa_pkg::BITPOS_W]);
              cur_idx_next = cmd.idx;
              state_next = S_FREE;
            end
            default: begin
              res_set = 1'b1;
              res_status_d = lfsa_pkg::ST_RANGE;
            end
          endcase
        end
      end
      S_FREE: begin
        res_set = 1'b1;
        state_next = S_IDLE;
        if (!rd_word[free_pos]) begin
          res_status_d = lfsa_pkg::ST_ALREADY_FREE;
        end else begin
          wr_en = 1'b1;
          wr_addr = lfsa_pkg::wnum_t'(cur_idx[lfsa_pkg::IDX_W-1:lfsa_pkg::BITPOS_W]);
          wr_data = rd_word & ~(lfsa_pkg::word_t'(1) << free_pos);
          if (cur_idx < hint) begin
            hint_next = cur_idx;
          end
          if (used_count != '0) begin
            used_count_next = used_count - 1'b1;
          end
        end
      end
      S_SCAN1: begin
        if (hit.found) begin
          wr_en = 1'b1;
          wr_data = scan_word | (lfsa_pkg::word_t'(1) << hit.pos);
          word_buf_next = wr_data;
          use_buf_next = 1'b1;
          start_next = lfsa_pkg::wnum_t'(hit.pos) + 1'b1;
          grant_next = {w[lfsa_pkg::BITPOS_W-1:0], hit.pos};
          used_count_next = used_count + 1'b1;
          state_next = S_SCAN2;
        end else if (next_ok) begin
          rd_en = 1'b1;
          rd_addr = w_inc;
          w_next = w_inc;
          start_next = '0;
        end else begin
          res_set = 1'b1;
          res_status_d = lfsa_pkg::ST_FULL;
          state_next = S_IDLE;
        end
      end
      S_SCAN2: begin
        if (hit.found) begin
          hint_next = {w[lfsa_pkg::BITPOS_W-1:0], hit.pos};
          res_set = 1'b1;
          res_slot_d = grant;
          state_next = S_IDLE;
        end else if (next_ok) begin
          rd_en = 1'b1;
          rd_addr = w_inc;
          w_next = w_inc;
          start_next = '0;
          use_buf_next = 1'b0;
        end else begin
          hint_next = grant;
          res_set = 1'b1;
          res_slot_d = grant;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hint <= '0;
      used_count <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      hint <= hint_next;
      used_count <= used_count_next;
      if (res_set) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    w <= w_next;
    start <= start_next;
    use_buf <= use_buf_next;
    word_buf <= word_buf_next;
    cur_idx <= cur_idx_next;
    grant <= grant_next;
    if (res_set) begin
      res_status <= res_status_d;
      res_slot <= res_slot_d;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
      rdv_q <= 1'b0;
    end else begin
      if (wr_en) begin
        wvalid[wr_addr[AW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        rdv_q <= wvalid[rd_addr[AW-1:0]];
      end
    end
  end

  a_pop_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |-> (!res_valid || res_ready))
    else $error("command taken while the result register is still occupied");

  a_grant_counts: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN1 && hit.found) |=> (used_count == $past(used_count) + 1'b1))
    else $error("grant did not bump the used count");

  a_fail_zero_slot: assert property (@(posedge clk) disable iff (rst)
    (res_set && res_status_d != lfsa_pkg::ST_OK) |-> (res_slot_d == '0))
    else $error("failed request carries a nonzero slot");

  a_grant_in_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN1 && hit.found) |-> (lfsa_pkg::cnt_t'({w[lfsa_pkg::BITPOS_W-1:0], hit.pos})
                                          < lim))
    else $error("granted slot lies at or beyond the limit");

endmodule
